>>> rtl/nfr_pkg.sv
// Shared types and constants for the normal frame rotate unit.
// No dependencies; the datapath modules and the top level refer to this package by scoped names.
package nfr_pkg;

	localparam int ROOT_W    = 32;
	localparam int SQ_STEPS  = ROOT_W;
	localparam int RAD_W     = 2 * ROOT_W;
	localparam int SQ_REM_W  = ROOT_W + 4;
	localparam int DIV_NUM_W = 50;
	localparam int DIV_DEN_W = ROOT_W;
	localparam int DIV_Q_W   = 17;
	localparam int DIV_R_W   = DIV_NUM_W + 1;
	localparam int T_SHIFT   = 30;
	localparam int B_SHIFT   = 16;
	localparam int OUT_SHIFT = 14;

	typedef logic signed [15:0] q14_t;
	typedef q14_t [2:0] vec3_t;
	typedef logic signed [DIV_Q_W:0] quot_t;
	typedef quot_t [2:0] quot3_t;

	typedef struct packed {
		vec3_t             l;
		vec3_t             n;
		logic [2:0][15:0]  c_mag;
		logic [2:0]        c_neg;
		logic [31:0]       s;
		logic [31:0]       n2;
		logic              deg;
	} front_t;

	typedef struct packed {
		vec3_t             l;
		vec3_t             n;
		logic [ROOT_W-1:0] rn;
		logic              deg;
	} sidet_t;

	typedef struct packed {
		vec3_t l;
		vec3_t n;
		vec3_t t;
		logic  deg;
	} sideb_t;

	localparam int SIDE_W = $bits(sideb_t);

endpackage

>>> rtl/nfr_front.sv
// Front end: input capture, helper axis choice, cross product and squared lengths.
// Depends on nfr_pkg.
module nfr_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  nfr_pkg::vec3_t  l,
	input  nfr_pkg::vec3_t  n,
	output logic            vout,
	output nfr_pkg::front_t fr
);

	logic [2:0]       vld_q;
	nfr_pkg::vec3_t   l_s1, n_s1, l_s2, n_s2;
	logic [2:0][15:0] cm_s2;
	logic [2:0]       cn_s2;
	logic             selx_s2;
	logic [31:0]      sqx_s2, sqy_s2, sqz_s2;
	nfr_pkg::front_t  fr_s3;
	logic [15:0]      ax, ay, az;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[1:0], vin};
		end
	end

	always_comb begin
		ax = n_s1[0][15] ? 16'(~n_s1[0] + 16'sd1) : n_s1[0];
		ay = n_s1[1][15] ? 16'(~n_s1[1] + 16'sd1) : n_s1[1];
		az = n_s1[2][15] ? 16'(~n_s1[2] + 16'sd1) : n_s1[2];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			l_s1 <= l;
			n_s1 <= n;
			l_s2 <= l_s1;
			n_s2 <= n_s1;
			selx_s2 <= ax < ay;
			sqx_s2 <= ax * ax;
			sqy_s2 <= ay * ay;
			sqz_s2 <= az * az;
			if (ax < ay) begin
				cm_s2 <= {ay, az, 16'd0};
				cn_s2 <= {~n_s1[1][15] & (n_s1[1] != 16'sd0), n_s1[2][15], 1'b0};
			end else begin
				cm_s2 <= {ax, 16'd0, az};
				cn_s2 <= {n_s1[0][15], 1'b0, ~n_s1[2][15] & (n_s1[2] != 16'sd0)};
			end
			fr_s3.l     <= l_s2;
			fr_s3.n     <= n_s2;
			fr_s3.c_mag <= cm_s2;
			fr_s3.c_neg <= cn_s2;
			fr_s3.s     <= sqz_s2 + (selx_s2 ? sqy_s2 : sqx_s2);
			fr_s3.n2    <= sqx_s2 + sqy_s2 + sqz_s2;
			fr_s3.deg   <= (sqz_s2 + (selx_s2 ? sqy_s2 : sqx_s2)) == 32'd0;
		end
	end

	assign vout = vld_q[2];
	assign fr   = fr_s3;

endmodule

>>> rtl/nfr_isqrt.sv
// Pipelined integer square roots of both squared lengths, one root bit per stage.
// Depends on nfr_pkg.
module nfr_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vin,
	input  nfr_pkg::front_t           fr_in,
	output logic                      vout,
	output nfr_pkg::front_t           fr_out,
	output logic [nfr_pkg::ROOT_W-1:0] rc,
	output logic [nfr_pkg::ROOT_W-1:0] rn
);

	localparam int N = nfr_pkg::SQ_STEPS;

	typedef struct packed {
		logic [nfr_pkg::RAD_W-1:0]    x;
		logic [nfr_pkg::SQ_REM_W-1:0] rem;
		logic [nfr_pkg::ROOT_W-1:0]   root;
	} sq_t;

	function automatic sq_t sq_step(input sq_t a);
		sq_t                          r;
		logic [nfr_pkg::SQ_REM_W-1:0] sh;
		logic [nfr_pkg::SQ_REM_W-1:0] trial;
		sh    = {a.rem[nfr_pkg::SQ_REM_W-3:0], a.x[nfr_pkg::RAD_W-1 -: 2]};
		trial = {2'b00, a.root, 2'b01};
		r.x   = {a.x[nfr_pkg::RAD_W-3:0], 2'b00};
		if (sh >= trial) begin
			r.rem  = sh - trial;
			r.root = {a.root[nfr_pkg::ROOT_W-2:0], 1'b1};
		end else begin
			r.rem  = sh;
			r.root = {a.root[nfr_pkg::ROOT_W-2:0], 1'b0};
		end
		return r;
	endfunction

	logic [N-1:0]    vld_q;
	sq_t             c_s  [0:N-1];
	sq_t             n_s  [0:N-1];
	nfr_pkg::front_t fr_s [0:N-1];
	sq_t             c0, n0;

	always_comb begin
		c0.x    = {fr_in.s, 32'd0};
		c0.rem  = '0;
		c0.root = '0;
		n0.x    = {fr_in.n2, 32'd0};
		n0.rem  = '0;
		n0.root = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[N-2:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s[0]  <= sq_step(c0);
			n_s[0]  <= sq_step(n0);
			fr_s[0] <= fr_in;
		end
	end

	for (genvar k = 1; k < N; k++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				c_s[k]  <= sq_step(c_s[k-1]);
				n_s[k]  <= sq_step(n_s[k-1]);
				fr_s[k] <= fr_s[k-1];
			end
		end
	end

	assign vout   = vld_q[N-1];
	assign fr_out = fr_s[N-1];
	assign rc     = c_s[N-1].root;
	assign rn     = n_s[N-1].root;

endmodule

>>> rtl/nfr_div3.sv
// Three-lane pipelined restoring divider with rounding to nearest, one quotient bit
// per stage, carrying a side word alongside. Depends on nfr_pkg.
module nfr_div3 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                vin,
	input  logic [2:0][nfr_pkg::DIV_NUM_W-1:0]  num_mag,
	input  logic [2:0]                          num_neg,
	input  logic [nfr_pkg::DIV_DEN_W-1:0]       den,
	input  logic [nfr_pkg::SIDE_W-1:0]          side_in,
	output logic                                vout,
	output nfr_pkg::quot3_t                     quot,
	output logic [nfr_pkg::SIDE_W-1:0]          side_out
);

	localparam int Q = nfr_pkg::DIV_Q_W;
	localparam int R = nfr_pkg::DIV_R_W;

	logic [Q+1:0]                   vld_q;
	logic [2:0][R-1:0]              rem_s  [0:Q-1];
	logic [2:0][Q-1:0]              quo_s  [0:Q];
	logic [nfr_pkg::DIV_DEN_W-1:0]  den_s  [0:Q-1];
	logic [2:0]                     neg_s  [0:Q];
	logic [nfr_pkg::SIDE_W-1:0]     side_s [0:Q+1];
	nfr_pkg::quot3_t                quot_s;
	logic [nfr_pkg::DIV_DEN_W-1:0]  den_eff;

	assign den_eff = (den == '0) ? nfr_pkg::DIV_DEN_W'(1) : den;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[Q:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				rem_s[0][j] <= R'(num_mag[j]) + R'(den_eff >> 1);
				quo_s[0][j] <= '0;
			end
			den_s[0]  <= den_eff;
			neg_s[0]  <= num_neg;
			side_s[0] <= side_in;
			for (int k = 0; k < Q-1; k++) begin
				den_s[k+1] <= den_s[k];
			end
			for (int k = 0; k < Q; k++) begin
				neg_s[k+1] <= neg_s[k];
			end
			for (int k = 0; k <= Q; k++) begin
				side_s[k+1] <= side_s[k];
			end
			for (int j = 0; j < 3; j++) begin
				quot_s[j] <= neg_s[Q][j] ? -$signed({1'b0, quo_s[Q][j]})
					: $signed({1'b0, quo_s[Q][j]});
			end
		end
	end

	for (genvar k = 0; k < Q; k++) begin : g_step
		localparam int B = Q - 1 - k;
		localparam logic [Q-1:0] BIT = Q'(1) << B;
		logic [R-1:0] dsh;
		assign dsh = R'(den_s[k]) << B;
		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					if (rem_s[k][j] >= dsh) begin
						quo_s[k+1][j] <= quo_s[k][j] | BIT;
					end else begin
						quo_s[k+1][j] <= quo_s[k][j];
					end
				end
			end
		end
		if (k < Q - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					for (int j = 0; j < 3; j++) begin
						rem_s[k+1][j] <= (rem_s[k][j] >= dsh) ? rem_s[k][j] - dsh
							: rem_s[k][j];
					end
				end
			end
		end
	end

	assign vout     = vld_q[Q+1];
	assign quot     = quot_s;
	assign side_out = side_s[Q+1];

endmodule

>>> rtl/nfr_cross.sv
// Cross product of the tangent with the normal, split into magnitude and sign for
// the bitangent divider. Depends on nfr_pkg.
module nfr_cross (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vin,
	input  nfr_pkg::quot3_t             tq,
	input  nfr_pkg::sidet_t             side_in,
	output logic                        vout,
	output logic [2:0][31:0]            e_mag,
	output logic [2:0]                  e_neg,
	output logic [nfr_pkg::ROOT_W-1:0]  rn,
	output nfr_pkg::sideb_t             side_out
);

	logic [1:0]                      vld_q;
	logic signed [31:0]              pa_s1 [0:2];
	logic signed [31:0]              pb_s1 [0:2];
	nfr_pkg::vec3_t                  t_s1;
	nfr_pkg::sidet_t                 sd_s1;
	logic [2:0][31:0]                em_s2;
	logic [2:0]                      en_s2;
	logic [nfr_pkg::ROOT_W-1:0]      rn_s2;
	nfr_pkg::sideb_t                 sd_s2;
	nfr_pkg::vec3_t                  t;
	logic signed [32:0]              e [0:2];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			t[j] = tq[j][15:0];
			e[j] = 33'(pa_s1[j]) - 33'(pb_s1[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= $signed(t[1]) * $signed(side_in.n[2]);
			pb_s1[0] <= $signed(t[2]) * $signed(side_in.n[1]);
			pa_s1[1] <= $signed(t[2]) * $signed(side_in.n[0]);
			pb_s1[1] <= $signed(t[0]) * $signed(side_in.n[2]);
			pa_s1[2] <= $signed(t[0]) * $signed(side_in.n[1]);
			pb_s1[2] <= $signed(t[1]) * $signed(side_in.n[0]);
			t_s1  <= t;
			sd_s1 <= side_in;
			for (int j = 0; j < 3; j++) begin
				em_s2[j] <= e[j][32] ? 32'(-e[j]) : 32'(e[j]);
				en_s2[j] <= e[j][32];
			end
			rn_s2     <= sd_s1.rn;
			sd_s2.l   <= sd_s1.l;
			sd_s2.n   <= sd_s1.n;
			sd_s2.t   <= t_s1;
			sd_s2.deg <= sd_s1.deg;
		end
	end

	assign vout     = vld_q[1];
	assign e_mag    = em_s2;
	assign e_neg    = en_s2;
	assign rn       = rn_s2;
	assign side_out = sd_s2;

endmodule

>>> rtl/nfr_combine.sv
// Final weighted sum of bitangent, normal and tangent, rounding and saturation; degenerate results are forced to zero.
// Depends on nfr_pkg.
module nfr_combine (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vin,
	input  nfr_pkg::quot3_t bq,
	input  nfr_pkg::sideb_t side_in,
	output logic            vout,
	output nfr_pkg::vec3_t  world,
	output logic            deg,
	output logic            sat
);

	typedef struct packed {
		nfr_pkg::q14_t v;
		logic          sat;
	} clamp_t;

	function automatic clamp_t round_clamp(input logic signed [35:0] sum);
		clamp_t             r;
		logic [35:0]        mag;
		logic [21:0]        q;
		logic signed [22:0] v;
		mag = sum[35] ? 36'(-sum) : 36'(sum);
		q   = 22'((mag + 36'd8192) >> nfr_pkg::OUT_SHIFT);
		v   = sum[35] ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (v > 23'sd32767) begin
			r.v   = 16'sh7fff;
			r.sat = 1'b1;
		end else if (v < -23'sd32768) begin
			r.v   = 16'sh8000;
			r.sat = 1'b1;
		end else begin
			r.v   = v[15:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	logic [2:0]          vld_q;
	logic signed [33:0]  pb_s1 [0:2];
	logic signed [31:0]  pn_s1 [0:2];
	logic signed [31:0]  pt_s1 [0:2];
	logic                deg_s1, deg_s2, deg_s3, sat_s3;
	logic signed [35:0]  sum_s2 [0:2];
	nfr_pkg::vec3_t      w_s3;
	clamp_t              rc [0:2];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			rc[j] = round_clamp(sum_s2[j]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[1:0], vin};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				pb_s1[j]  <= $signed(side_in.l[0]) * $signed(bq[j]);
				pn_s1[j]  <= $signed(side_in.l[1]) * $signed(side_in.n[j]);
				pt_s1[j]  <= $signed(side_in.l[2]) * $signed(side_in.t[j]);
				sum_s2[j] <= 36'(pb_s1[j]) + 36'(pn_s1[j]) + 36'(pt_s1[j]);
				w_s3[j]   <= deg_s2 ? 16'sd0 : rc[j].v;
			end
			deg_s1 <= side_in.deg;
			deg_s2 <= deg_s1;
			deg_s3 <= deg_s2;
			sat_s3 <= ~deg_s2 & (rc[0].sat | rc[1].sat | rc[2].sat);
		end
	end

	assign vout  = vld_q[2];
	assign world = w_s3;
	assign deg   = deg_s3;
	assign sat   = sat_s3;

endmodule

>>> rtl/normal_frame_rotate_unit.sv
// Accepts one word per cycle while no result is held by result_stall.
// Most of the depth lies in the 32 root stages, one root bit a stage, and the two 19-stage dividers.
// The whole pipeline freezes while a result is held by result_stall.
// Asynchronous active-low reset clears all valid bits; data registers are not reset.
// Depends on nfr_pkg and the nfr_front, nfr_isqrt, nfr_div3, nfr_cross, nfr_combine modules.
module normal_frame_rotate_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [15:0] local_x,
	input  logic [15:0] local_y,
	input  logic [15:0] local_z,
	input  logic [15:0] normal_x,
	input  logic [15:0] normal_y,
	input  logic [15:0] normal_z,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] world_x,
	output logic [15:0] world_y,
	output logic [15:0] world_z,
	output logic        degenerate,
	output logic        saturated
);

	logic                             en;
	logic                             v_fr, v_sq, v_dt, v_cr, v_db;
	nfr_pkg::front_t                  fr, fr_sq;
	logic [nfr_pkg::ROOT_W-1:0]       rc, rn, rn_cr;
	logic [2:0][nfr_pkg::DIV_NUM_W-1:0] t_num, b_num;
	nfr_pkg::sidet_t                  sdt;
	logic [nfr_pkg::SIDE_W-1:0]       sdt_w, sdt_o, sdb_w, sdb_o;
	nfr_pkg::quot3_t                  tq, bq;
	logic [2:0][31:0]                 e_mag;
	logic [2:0]                       e_neg;
	nfr_pkg::sideb_t                  sdb;
	nfr_pkg::vec3_t                   lv, nv, world;

	assign en         = ~(result_valid & result_stall);
	assign item_stall = result_valid & result_stall;

	assign lv = {local_z, local_y, local_x};
	assign nv = {normal_z, normal_y, normal_x};

	nfr_front u_front (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(item_valid),
		.l(lv), .n(nv), .vout(v_fr), .fr(fr)
	);

	nfr_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_fr), .fr_in(fr),
		.vout(v_sq), .fr_out(fr_sq), .rc(rc), .rn(rn)
	);

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			t_num[j] = nfr_pkg::DIV_NUM_W'(fr_sq.c_mag[j]) << nfr_pkg::T_SHIFT;
			b_num[j] = nfr_pkg::DIV_NUM_W'(e_mag[j]) << nfr_pkg::B_SHIFT;
		end
		sdt.l   = fr_sq.l;
		sdt.n   = fr_sq.n;
		sdt.rn  = rn;
		sdt.deg = fr_sq.deg;
	end

	assign sdt_w = nfr_pkg::SIDE_W'(sdt);

	nfr_div3 u_div_t (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_sq),
		.num_mag(t_num), .num_neg(fr_sq.c_neg), .den(rc), .side_in(sdt_w),
		.vout(v_dt), .quot(tq), .side_out(sdt_o)
	);

	nfr_cross u_cross (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_dt), .tq(tq),
		.side_in(nfr_pkg::sidet_t'(sdt_o[$bits(nfr_pkg::sidet_t)-1:0])),
		.vout(v_cr), .e_mag(e_mag), .e_neg(e_neg), .rn(rn_cr), .side_out(sdb)
	);

	assign sdb_w = nfr_pkg::SIDE_W'(sdb);

	nfr_div3 u_div_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_cr),
		.num_mag(b_num), .num_neg(e_neg), .den(rn_cr), .side_in(sdb_w),
		.vout(v_db), .quot(bq), .side_out(sdb_o)
	);

	nfr_combine u_combine (
		.clk(clk), .arst_n(arst_n), .en(en), .vin(v_db), .bq(bq),
		.side_in(nfr_pkg::sideb_t'(sdb_o)),
		.vout(result_valid), .world(world), .deg(degenerate), .sat(saturated)
	);

	assign world_x = world[0];
	assign world_y = world[1];
	assign world_z = world[2];

endmodule

>>> rtl/nfr_checker.sv
// Port-level checks for the normal frame rotate unit, bound to its top level.
// Depends only on the top level's ports.
module nfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [15:0] world_x,
	input logic [15:0] world_y,
	input logic [15:0] world_z,
	input logic        degenerate,
	input logic        saturated
);

	// A held result word keeps its components and its degenerate flag.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(world_x)
			&& $stable(world_y) && $stable(world_z) && $stable(degenerate))
		else $error("held result word changed");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled without a held result");

	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && degenerate |-> world_x == 16'd0 && world_y == 16'd0
			&& world_z == 16'd0 && !saturated)
		else $error("degenerate result not zero");

	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && saturated |-> world_x == 16'h7fff || world_x == 16'h8000
			|| world_y == 16'h7fff || world_y == 16'h8000
			|| world_z == 16'h7fff || world_z == 16'h8000)
		else $error("saturated flag without a clamped component");

endmodule

bind normal_frame_rotate_unit nfr_checker u_nfr_checker (.*);

>>> sim/tb_normal_frame_rotate_unit.sv
// Testbench for normal_frame_rotate_unit: drives local directions and normals, predicts each
// rotated direction with an integer model of the frame construction and checks every result.
// Depends on the RTL top level only; the block has no configuration registers.
module tb_normal_frame_rotate_unit;

	typedef struct {
		logic [15:0] wx;
		logic [15:0] wy;
		logic [15:0] wz;
		logic        deg;
		logic        sat;
	} world_t;

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [15:0] local_x, local_y, local_z;
	logic [15:0] normal_x, normal_y, normal_z;
	logic        result_valid;
	logic        result_stall;
	logic [15:0] world_x, world_y, world_z;
	logic        degenerate;
	logic        saturated;

	world_t      expected_worlds[$];
	int          error_count;
	int          cycle_count;
	int          stall_left;
	bit          quiet_phase;
	bit          sink_idle_on;

	normal_frame_rotate_unit dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall),
		.local_x(local_x), .local_y(local_y), .local_z(local_z),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
		.result_valid(result_valid), .result_stall(result_stall),
		.world_x(world_x), .world_y(world_y), .world_z(world_z),
		.degenerate(degenerate), .saturated(saturated)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint round_div(longint num, longint unsigned den);
		longint unsigned mag;
		longint unsigned q;
		if (den == 0)
			den = 1;
		mag = (num < 0) ? longint'(-num) : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic world_t rotate_direction(logic [15:0] lx, logic [15:0] ly,
			logic [15:0] lz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		world_t          w;
		longint          l[3], n[3], c[3], t[3], e[3], b[3];
		longint          sum, v;
		longint unsigned s, n2, rc, rn;
		l[0] = longint'($signed(lx));
		l[1] = longint'($signed(ly));
		l[2] = longint'($signed(lz));
		n[0] = longint'($signed(nx));
		n[1] = longint'($signed(ny));
		n[2] = longint'($signed(nz));
		if ((n[0] < 0 ? -n[0] : n[0]) < (n[1] < 0 ? -n[1] : n[1])) begin
			c[0] = 0; c[1] = n[2]; c[2] = -n[1];
		end else begin
			c[0] = -n[2]; c[1] = 0; c[2] = n[0];
		end
		s = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
		w = '{16'd0, 16'd0, 16'd0, 1'b1, 1'b0};
		if (s == 0)
			return w;
		n2 = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
		rc = int_sqrt(s << 32);
		rn = int_sqrt(n2 << 32);
		if (rn == 0)
			rn = 1;
		for (int j = 0; j < 3; j++)
			t[j] = round_div(c[j] * 64'sd1073741824, rc);
		e[0] = t[1] * n[2] - t[2] * n[1];
		e[1] = t[2] * n[0] - t[0] * n[2];
		e[2] = t[0] * n[1] - t[1] * n[0];
		for (int j = 0; j < 3; j++)
			b[j] = round_div(e[j] * 64'sd65536, rn);
		w.deg = 1'b0;
		for (int j = 0; j < 3; j++) begin
			sum = l[0] * b[j] + l[1] * n[j] + l[2] * t[j];
			v = round_div(sum, 16384);
			if (v > 32767) begin
				v = 32767;
				w.sat = 1'b1;
			end else if (v < -32768) begin
				v = -32768;
				w.sat = 1'b1;
			end
			if (j == 0) w.wx = v[15:0];
			else if (j == 1) w.wy = v[15:0];
			else w.wz = v[15:0];
		end
		return w;
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("Mismatch on %s at cycle %0d: got %h, expected %h", what, cycle_count,
			got, want);
		error_count++;
	endtask

	// Sends one word, at random after an idle burst, with no idle burst in the quiet end of the run.
	task automatic send_word(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
			logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		int gap;
		gap = 0;
		if (!quiet_phase && $urandom_range(0, 3) == 0)
			gap = $urandom_range(1, 9);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		local_x <= lx; local_y <= ly; local_z <= lz;
		normal_x <= nx; normal_y <= ny; normal_z <= nz;
		expected_worlds.push_back(rotate_direction(lx, ly, lz, nx, ny, nz));
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic pause_source();
		item_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] pick_component();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'h4000;
			4: return 16'hC000;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic test_directed();
		send_word(16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
		send_word(16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
		send_word(16'h0000, 16'h0000, 16'h4000, 16'h4000, 16'h0000, 16'h0000);
		send_word(16'h1234, 16'h2345, 16'h3456, 16'h0000, 16'h0000, 16'h0000);
		send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
		send_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
		send_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_word(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001);
		send_word(16'h4000, 16'h4000, 16'h4000, 16'h2000, 16'hE000, 16'h0000);
		send_word(16'h4000, 16'hC000, 16'h4000, 16'h2000, 16'h2001, 16'h1000);
		send_word(16'h0001, 16'hFFFF, 16'h0001, 16'h0001, 16'h0000, 16'h0000);
		send_word(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0000, 16'h0001, 16'hFFFF);
		send_word(16'h7FFF, 16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0001);
		send_word(16'h2D41, 16'h2D41, 16'h0000, 16'h2D41, 16'h2D41, 16'h0000);
		send_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
		send_word(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
		pause_source();
	endtask

	// Mostly random words scaled to a quarter of full range, with raw and edge words mixed in.
	task automatic test_random();
		int kind;
		logic [15:0] f[6];
		for (int i = 0; i < 1200; i++) begin
			quiet_phase = (i >= 1050);
			kind = $urandom_range(0, 9);
			for (int j = 0; j < 6; j++)
				f[j] = 16'($urandom);
			if (kind < 6) begin
				for (int j = 0; j < 6; j++)
					f[j] = 16'($signed(f[j]) >>> 2);
			end else if (kind < 8) begin
				for (int j = 0; j < 6; j++)
					f[j] = pick_component();
			end else if (kind == 8) begin
				f[3] = 16'h0000;
				f[5] = 16'h0000;
			end
			send_word(f[0], f[1], f[2], f[3], f[4], f[5]);
		end
		pause_source();
	endtask

	// The sink stalls in bursts of random length.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (quiet_phase || !sink_idle_on) begin
			result_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			result_stall <= 1'b1;
			stall_left <= $urandom_range(1, 9) - 1;
		end else begin
			result_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			cycle_count <= cycle_count + 1;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_worlds.size() == 0) begin
				report_mismatch("unexpected result", world_x, 16'h0000);
			end else begin
				world_t w;
				w = expected_worlds.pop_front();
				if (world_x !== w.wx) report_mismatch("world_x", world_x, w.wx);
				if (world_y !== w.wy) report_mismatch("world_y", world_y, w.wy);
				if (world_z !== w.wz) report_mismatch("world_z", world_z, w.wz);
				if (degenerate !== w.deg)
					report_mismatch("degenerate", 16'(degenerate), 16'(w.deg));
				if (saturated !== w.sat)
					report_mismatch("saturated", 16'(saturated), 16'(w.sat));
			end
		end
		if (cycle_count > 200000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		quiet_phase = 1'b0;
		sink_idle_on = 1'b1;
		arst_n = 1'b0;
		item_valid = 1'b0;
		local_x = '0; local_y = '0; local_z = '0;
		normal_x = '0; normal_y = '0; normal_z = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		while (expected_worlds.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
